// ===== rtl/core/gpc_pkg.sv =====
`default_nettype none

package gpc_pkg;

	localparam int unsigned WORD_W = 32;

	// item kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_IDLE  = 2'd2;

	// register map
	localparam logic [3:0] REG_DIR     = 4'd0;
	localparam logic [3:0] REG_OUT     = 4'd1;
	localparam logic [3:0] REG_OUT_SET = 4'd2;
	localparam logic [3:0] REG_OUT_CLR = 4'd3;
	localparam logic [3:0] REG_OUT_TGL = 4'd4;
	localparam logic [3:0] REG_INPUT   = 4'd5;
	localparam logic [3:0] REG_INT_EN  = 4'd6;
	localparam logic [3:0] REG_TYPE    = 4'd7;
	localparam logic [3:0] REG_POL     = 4'd8;
	localparam logic [3:0] REG_BOTH    = 4'd9;
	localparam logic [3:0] REG_STATUS  = 4'd10;
	localparam logic [3:0] REG_STS_CLR = 4'd11;
	localparam logic [3:0] REG_PULL_EN = 4'd12;
	localparam logic [3:0] REG_PULL_SEL = 4'd13;

	typedef struct packed {
		logic [1:0]        kind;
		logic [3:0]        reg_index;
		logic [WORD_W-1:0] write_data;
		logic [WORD_W-1:0] pins_in;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic [WORD_W-1:0] pins_out;
		logic [WORD_W-1:0] pins_oe;
		logic [WORD_W-1:0] pull_on;
		logic [WORD_W-1:0] pull_up;
		logic              irq;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/gpc_if.sv =====
`default_nettype none

// request channel: one bus access or idle sample per item
interface gpc_req_if
	import gpc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [3:0]        reg_index;
	logic [WORD_W-1:0] write_data;
	logic [WORD_W-1:0] pins_in;

	modport source (output valid, kind, reg_index, write_data, pins_in, input ready);
	modport sink (input valid, kind, reg_index, write_data, pins_in, output ready);
endinterface

// response channel: one result per request item
interface gpc_rsp_if
	import gpc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] read_data;
	logic [WORD_W-1:0] pins_out;
	logic [WORD_W-1:0] pins_oe;
	logic [WORD_W-1:0] pull_on;
	logic [WORD_W-1:0] pull_up;
	logic              irq;

	modport source (output valid, read_data, pins_out, pins_oe, pull_on, pull_up, irq,
		input ready);
	modport sink (input valid, read_data, pins_out, pins_oe, pull_on, pull_up, irq,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gpio_controller_with_pin_interrupts.sv =====
// GPIO controller, PIN_COUNT pins, with per-pin edge and level interrupts.
// req channel: each item is a register read, a register write or an idle
//   sample, and always carries the current pin levels in pins_in.
// rsp channel: exactly one item per request, in order: read_data (zero
//   unless a read), the pin drive, output enable and pull settings after
//   the request, and irq (any enabled pending status bit).
// Path: a request is registered in the input stage, processed by one level
//   of bitwise logic, registered in the result register and shown on rsp
//   when the response side is free.
// Throughput: one item per cycle when rsp is not stalled, set by the single
//   input register and single result register around the bitwise update logic.
// Stall: while a response waits, the input stage still takes one more
//   request; req.ready drops only when both registers are full.
// Reset: arst_n clears all control and interrupt registers and the stored
//   previous pin sample (so a pin that is high on the first request counts
//   as a rising edge) and empties both stages.
`default_nettype none

module gpio_controller_with_pin_interrupts
	import gpc_pkg::*;
#(
	parameter int unsigned PIN_COUNT = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	gpc_req_if.sink   req,
	gpc_rsp_if.source rsp
);

	item_t   req_item, item_s1;
	result_t core_result, rsp_result;
	logic    valid_s1, load_ready, advance;

	// request payload into one struct
	assign req_item.kind       = req.kind;
	assign req_item.reg_index  = req.reg_index;
	assign req_item.write_data = req.write_data;
	assign req_item.pins_in    = req.pins_in;

	assign advance = valid_s1 && load_ready;

	gpc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_item  (req_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	gpc_core #(
		.PIN_COUNT (PIN_COUNT)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.advance (advance),
		.result  (core_result)
	);

	gpc_out_stage u_out_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (valid_s1),
		.load_ready  (load_ready),
		.load_result (core_result),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_result  (rsp_result)
	);

	// response payload out of the struct
	assign rsp.read_data = rsp_result.read_data;
	assign rsp.pins_out  = rsp_result.pins_out;
	assign rsp.pins_oe   = rsp_result.pins_oe;
	assign rsp.pull_on   = rsp_result.pull_on;
	assign rsp.pull_up   = rsp_result.pull_up;
	assign rsp.irq       = rsp_result.irq;

endmodule

`default_nettype wire

// ===== rtl/core/gpc_in_stage.sv =====
`default_nettype none

module gpc_in_stage
	import gpc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire item_t in_item,
	input  wire logic  advance,
	output logic       valid_s1,
	output item_t      item_s1
);

	// stage can take an item when empty or when its item moves on this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/gpc_core.sv =====
`default_nettype none

module gpc_core
	import gpc_pkg::*;
#(
	parameter int unsigned PIN_COUNT = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t item_s1,
	input  wire logic  advance,
	output result_t    result
);

	logic [PIN_COUNT-1:0] dir_q, out_q, pull_en_q, pull_sel_q;
	logic [PIN_COUNT-1:0] int_en_q, type_q, pol_q, both_q, pend_q, prev_q;

	logic [PIN_COUNT-1:0] dir_d, out_d, pull_en_d, pull_sel_d;
	logic [PIN_COUNT-1:0] int_en_d, type_d, pol_d, both_d, pend_d, pend_clr;

	logic [PIN_COUNT-1:0] data, pins, rd;
	logic [PIN_COUNT-1:0] rise, fall, edge_hit, level_hit, events;
	logic                 is_read, is_write;

	// pins above PIN_COUNT drop out here
	assign data     = item_s1.write_data[PIN_COUNT-1:0];
	assign pins     = item_s1.pins_in[PIN_COUNT-1:0];
	assign is_read  = (item_s1.kind == KIND_READ);
	assign is_write = (item_s1.kind == KIND_WRITE);

	// read mux over the state before this item
	always_comb begin
		rd = '0;
		if (is_read) begin
			unique case (item_s1.reg_index)
				REG_DIR:      rd = dir_q;
				REG_OUT:      rd = out_q;
				REG_INPUT:    rd = pins;
				REG_INT_EN:   rd = int_en_q;
				REG_TYPE:     rd = type_q;
				REG_POL:      rd = pol_q;
				REG_BOTH:     rd = both_q;
				REG_STATUS:   rd = pend_q;
				REG_PULL_EN:  rd = pull_en_q;
				REG_PULL_SEL: rd = pull_sel_q;
				default:      rd = '0;
			endcase
		end
	end

	// register writes, including atomic set/clear/toggle and status clear
	always_comb begin
		dir_d      = dir_q;
		out_d      = out_q;
		pull_en_d  = pull_en_q;
		pull_sel_d = pull_sel_q;
		int_en_d   = int_en_q;
		type_d     = type_q;
		pol_d      = pol_q;
		both_d     = both_q;
		pend_clr   = pend_q;
		if (is_write) begin
			unique case (item_s1.reg_index)
				REG_DIR:      dir_d      = data;
				REG_OUT:      out_d      = data;
				REG_OUT_SET:  out_d      = out_q | data;
				REG_OUT_CLR:  out_d      = out_q & ~data;
				REG_OUT_TGL:  out_d      = out_q ^ data;
				REG_INT_EN:   int_en_d   = data;
				REG_TYPE:     type_d     = data;
				REG_POL:      pol_d      = data;
				REG_BOTH:     both_d     = data;
				REG_STS_CLR:  pend_clr   = pend_q & ~data;
				REG_PULL_EN:  pull_en_d  = data;
				REG_PULL_SEL: pull_sel_d = data;
				default:      ;
			endcase
		end
	end

	// event detection with the updated configuration
	assign rise      = pins & ~prev_q;
	assign fall      = prev_q & ~pins;
	assign edge_hit  = (both_d & (rise | fall)) |
		(~both_d & ((pol_d & rise) | (~pol_d & fall)));
	assign level_hit = ~(pins ^ pol_d);
	assign events    = (type_d & edge_hit) | (~type_d & level_hit);
	assign pend_d    = pend_clr | (events & int_en_d);

	// state update when the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q      <= '0;
			out_q      <= '0;
			pull_en_q  <= '0;
			pull_sel_q <= '0;
			int_en_q   <= '0;
			type_q     <= '0;
			pol_q      <= '0;
			both_q     <= '0;
			pend_q     <= '0;
			prev_q     <= '0;
		end else if (advance) begin
			dir_q      <= dir_d;
			out_q      <= out_d;
			pull_en_q  <= pull_en_d;
			pull_sel_q <= pull_sel_d;
			int_en_q   <= int_en_d;
			type_q     <= type_d;
			pol_q      <= pol_d;
			both_q     <= both_d;
			pend_q     <= pend_d;
			prev_q     <= pins;
		end
	end

	// result shows the state after this item
	always_comb begin
		result.read_data = WORD_W'(rd);
		result.pins_out  = WORD_W'(out_d);
		result.pins_oe   = WORD_W'(dir_d);
		result.pull_on   = WORD_W'(pull_en_d);
		result.pull_up   = WORD_W'(pull_sel_d);
		result.irq       = |(pend_d & int_en_d);
	end

endmodule

`default_nettype wire

// ===== rtl/core/gpc_out_stage.sv =====
`default_nettype none

module gpc_out_stage
	import gpc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load_valid,
	output logic         load_ready,
	input  wire result_t load_result,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_result
);

	logic    valid_q;
	result_t result_q;

	// refill in the same cycle the held result is taken
	assign load_ready = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			result_q <= load_result;
		end
	end

endmodule

`default_nettype wire
